[rtl/assert_macros.svh]
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition now implies consequence on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ppid_pkg.sv]
package ppid_pkg;

  localparam int MEAS_W         = 16;
  localparam int GAIN_W         = 16;
  localparam int LIMIT_W        = 31;
  localparam int DB_W           = 15;
  localparam int ERR_W          = MEAS_W + 1;
  localparam int INTEG_W        = 32;
  localparam int DX_W           = ERR_W + 1;
  localparam int OUT_W          = 32;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int P_W     = GAIN_W + ERR_W;
  localparam int I_W     = GAIN_W + INTEG_W;
  localparam int D_W     = GAIN_W + DX_W;
  localparam int SUM_W   = I_W + 2;
  localparam int SHIFT_W = SUM_W - GAIN_FRAC_BITS;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0]   OUT_MAX   = {1'b0, {(OUT_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT       = 3'd0,
    REG_GAIN_P         = 3'd1,
    REG_GAIN_I         = 3'd2,
    REG_GAIN_D         = 3'd3,
    REG_INTEGRAL_LIMIT = 3'd4,
    REG_OUTPUT_LIMIT   = 3'd5,
    REG_DEADBAND       = 3'd6,
    REG_RATE_MODE      = 3'd7
  } ppid_reg_e;

  typedef struct packed {
    logic signed [MEAS_W-1:0] setpoint;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       integral_limit;
    logic [LIMIT_W-1:0]       output_limit;
    logic [DB_W-1:0]          deadband;
    logic                     rate_mode;
  } ppid_cfg_t;

  // Operands handed from the error/integral stage to the multiply stage.
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W-1:0] integ;
    logic signed [DX_W-1:0]    dx;
  } ppid_term_t;

endpackage

[rtl/ppid_in_if.sv]
interface ppid_in_if import ppid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [MEAS_W-1:0] measured_value;
  logic signed [MEAS_W-1:0] rate_feedback;

  modport source (output valid, measured_value, rate_feedback, input ready);
  modport sink   (input valid, measured_value, rate_feedback, output ready);
endinterface

[rtl/ppid_out_if.sv]
interface ppid_out_if import ppid_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] drive_value;

  modport source (output valid, drive_value, input ready);
  modport sink   (input valid, drive_value, output ready);
endinterface

[rtl/ppid_cfg_if.sv]
interface ppid_cfg_if import ppid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/ppid_integ.sv]
module ppid_integ import ppid_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppid_cfg_t                cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [MEAS_W-1:0] meas_i,
  input  logic signed [MEAS_W-1:0] rate_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ppid_term_t               term_o
);

  logic                      valid_q;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0]   prev_q;
  logic signed [ERR_W-1:0]   err_raw, err;
  logic [ERR_W-1:0]          mag;
  logic [ERR_W-1:0]          db_ext;
  logic signed [INTEG_W:0]   sum_wide;
  logic signed [INTEG_W-1:0] sum_sat;
  logic signed [INTEG_W-1:0] lim_pos;
  logic signed [DX_W-1:0]    dx;
  logic                      advance;
  ppid_term_t                term_q, term_d;

  assign in_ready_o = !valid_q || out_ready_i;
  assign advance    = in_valid_i && in_ready_o;

  always_comb begin
    err_raw = {cfg_i.setpoint[MEAS_W-1], cfg_i.setpoint} - {meas_i[MEAS_W-1], meas_i};
    mag     = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : ERR_W'(err_raw);
    db_ext  = ERR_W'(cfg_i.deadband);

    // Pull the error toward zero by the dead zone in rate mode.
    err = err_raw;
    if (cfg_i.rate_mode && (cfg_i.deadband != '0)) begin
      if (mag < db_ext) begin
        err = '0;
      end else if (!err_raw[ERR_W-1]) begin
        err = err_raw - $signed(db_ext);
      end else begin
        err = err_raw + $signed(db_ext);
      end
    end

    sum_wide = {integ_q[INTEG_W-1], integ_q} +
               {{(INTEG_W+1-ERR_W){err[ERR_W-1]}}, err};
    if (sum_wide[INTEG_W] != sum_wide[INTEG_W-1]) begin
      sum_sat = sum_wide[INTEG_W] ? INTEG_MIN : INTEG_MAX;
    end else begin
      sum_sat = sum_wide[INTEG_W-1:0];
    end

    lim_pos = INTEG_W'(cfg_i.integral_limit);
    integ_d = sum_sat;
    if (cfg_i.integral_limit != '0) begin
      if (sum_sat > lim_pos) begin
        integ_d = lim_pos;
      end else if (sum_sat < -lim_pos) begin
        integ_d = -lim_pos;
      end
    end

    if (cfg_i.rate_mode) begin
      dx = DX_W'(rate_i);
    end else begin
      dx = {err[ERR_W-1], err} - {prev_q[ERR_W-1], prev_q};
    end

    term_d.err   = err;
    term_d.integ = integ_d;
    term_d.dx    = dx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
      prev_q  <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (advance) begin
        integ_q <= integ_d;
        prev_q  <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      term_q <= term_d;
    end
  end

  assign out_valid_o = valid_q;
  assign term_o      = term_q;

endmodule

[rtl/ppid_mac.sv]
module ppid_mac import ppid_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ppid_cfg_t               cfg_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ppid_term_t              term_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] drive_o
);

  logic                      mul_valid_q, out_valid_q;
  logic                      mul_ready, mul_adv, out_adv;
  logic signed [P_W-1:0]     prod_p_q;
  logic signed [I_W-1:0]     prod_i_q;
  logic signed [D_W-1:0]     prod_d_q;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SHIFT_W-1:0] scaled, hi_lim, lo_lim, clamped;
  logic signed [OUT_W-1:0]   drive_q, drive_d;

  assign in_ready_o = !mul_valid_q || mul_ready;
  assign mul_ready  = !out_valid_q || out_ready_i;
  assign mul_adv    = in_valid_i && in_ready_o;
  assign out_adv    = mul_valid_q && mul_ready;

  always_comb begin
    sum    = SUM_W'(prod_p_q) + SUM_W'(prod_i_q) + SUM_W'(prod_d_q);
    scaled = SHIFT_W'(sum >>> GAIN_FRAC_BITS);

    if (cfg_i.output_limit != '0) begin
      hi_lim = SHIFT_W'({1'b0, cfg_i.output_limit});
      lo_lim = -hi_lim;
    end else begin
      hi_lim = SHIFT_W'(OUT_MAX);
      lo_lim = -hi_lim - SHIFT_W'(1);
    end

    clamped = scaled;
    if (scaled > hi_lim) begin
      clamped = hi_lim;
    end else if (scaled < lo_lim) begin
      clamped = lo_lim;
    end
    drive_d = OUT_W'(clamped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        mul_valid_q <= in_valid_i;
      end
      if (mul_ready) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_adv) begin
      prod_p_q <= cfg_i.gain_p * term_i.err;
      prod_i_q <= cfg_i.gain_i * term_i.integ;
      prod_d_q <= cfg_i.gain_d * term_i.dx;
    end
    if (out_adv) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

endmodule

[rtl/positional_pid_controller_unit.sv]
// Channel    Dir  Payload                          Handshake
// cfg_i      in   index[2:0], data[31:0]           valid/ready, ready always high
// sample_i   in   measured_value, rate_feedback    valid/ready
// result_o   out  drive_value                      valid/ready
//
// One item per cycle while result_o is not stalled; result_o.valid follows the accepting edge
// through the input register, error/integral stage, multiply stage and sum/clamp output register.
// The integral and previous error update in the error/integral stage, so each
// item sees the state left by the one before it.
// Reset clears the configuration, the integral and previous error, and empties every stage.
// A stall on result_o backs up stage by stage; sample_i.ready drops only when all stages hold an item.
`include "assert_macros.svh"

module positional_pid_controller_unit import ppid_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ppid_cfg_if.sink   cfg_i,
  ppid_in_if.sink    sample_i,
  ppid_out_if.source result_o
);

  ppid_cfg_t                cfg_q;
  logic                     in_valid_q;
  logic signed [MEAS_W-1:0] meas_q, rate_q;
  logic                     integ_ready, integ_valid, mac_ready;
  logic                     all_full;
  ppid_term_t               term;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (ppid_reg_e'(cfg_i.index))
        REG_SETPOINT:       cfg_q.setpoint       <= cfg_i.data[MEAS_W-1:0];
        REG_GAIN_P:         cfg_q.gain_p         <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_I:         cfg_q.gain_i         <= cfg_i.data[GAIN_W-1:0];
        REG_GAIN_D:         cfg_q.gain_d         <= cfg_i.data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_i.data[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_i.data[LIMIT_W-1:0];
        REG_DEADBAND:       cfg_q.deadband       <= cfg_i.data[DB_W-1:0];
        REG_RATE_MODE:      cfg_q.rate_mode      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign sample_i.ready = !in_valid_q || integ_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.valid && sample_i.ready) begin
      meas_q <= sample_i.measured_value;
      rate_q <= sample_i.rate_feedback;
    end
  end

  ppid_integ u_integ (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (integ_ready),
    .meas_i      (meas_q),
    .rate_i      (rate_q),
    .out_valid_o (integ_valid),
    .out_ready_i (mac_ready),
    .term_o      (term)
  );

  ppid_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (integ_valid),
    .in_ready_o  (mac_ready),
    .term_i      (term),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .drive_o     (result_o.drive_value)
  );

  assign all_full = in_valid_q && integ_valid && result_o.valid;

  `ASSERT_NEXT(a_accept_loads_input, sample_i.valid && sample_i.ready, in_valid_q, "item dropped")
  `ASSERT_NEXT(a_input_moves_on, in_valid_q && !integ_valid, integ_valid, "item stuck at input")
  `ASSERT_CLK(a_stall_only_when_full, !sample_i.ready |-> all_full, "input stalled with a free stage")

endmodule
